// File: rtl/core/wltc_pkg.sv
// Shared constants, tables and types of the write lifespan threshold counter.
`default_nettype none

package wltc_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned UB_W      = 21;
  localparam int unsigned SEQ_W     = 48;
  localparam int unsigned CNT_W     = 48;
  localparam int unsigned IDX_W     = 2;

  // Threshold pair geometry: three window multiples by four start multiples.
  localparam int unsigned NUM_R     = 3;
  localparam int unsigned NUM_G     = 4;
  localparam int unsigned NUM_PAIRS = NUM_R * NUM_G;
  localparam int unsigned PAIR_W    = $clog2(NUM_PAIRS);

  // Multiples in tenths; a threshold is unique_blocks times a tenth value.
  localparam int unsigned TEN_W     = 7;
  localparam int unsigned THR_W     = UB_W + TEN_W;
  localparam logic [TEN_W-1:0] R_TENTHS [NUM_R] = '{7'd4, 7'd8, 7'd16};
  localparam logic [TEN_W-1:0] G_TENTHS [NUM_G] = '{7'd8, 7'd16, 7'd32, 7'd64};

  // Lifespan scaling: 2560 = 2^11 + 2^9, twelve bits of growth.
  localparam int unsigned SCALE_HI_SH = 11;
  localparam int unsigned SCALE_LO_SH = 9;
  localparam int unsigned SCALE_W     = 12;

  // Sequence distance is counted in units of 256 writes.
  localparam int unsigned SEQ_SHIFT = 8;

  // Default sizes.
  localparam int unsigned DEF_NUM_BLOCKS   = 1048576;
  localparam int unsigned DEF_MAX_LIFESPAN = 67108864;

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic        REG_UNIQUE_BLOCKS = 1'b0;

  // Item kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // One classified item travelling through the queue.
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
  } wltc_item_t;

endpackage

`default_nettype wire

// File: rtl/core/write_lifespan_threshold_counter.sv
// Top level of the write lifespan threshold counter.
//
//   Port group  Direction  Handshake        Carries
//   in_*        input      in_valid/stall   kind, block_address
//   out_*       output     out_valid/stall  r_index, g_index, counts, last
//   APB         input      psel/penable     unique_blocks at byte address 0
//
// A write item holds the back part for its registered map read, its map update
// and lifespan, and its counter update, in that order.
// A report item is dequeued and then gives twelve results, one per pair.
// After reset the map's min(NUM_BLOCKS, 2^20) entries are cleared one entry
// a cycle, and in_stall stays high until that pass ends. A four-item queue
// keeps the input accepting while the back is busy or out_stall holds a result.
`default_nettype none

module write_lifespan_threshold_counter
  import wltc_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS   = DEF_NUM_BLOCKS,
  parameter int unsigned MAX_LIFESPAN = DEF_MAX_LIFESPAN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              in_kind,
  input  wire logic [ADDR_W-1:0] in_block_address,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [IDX_W-1:0]  out_r_index,
  output      logic [IDX_W-1:0]  out_g_index,
  output      logic [CNT_W-1:0]  out_within_count,
  output      logic [CNT_W-1:0]  out_beyond_g_count,
  output      logic              out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  logic            clearing;
  logic            queue_full;
  logic            queue_empty;
  logic            push;
  logic            pop;
  wltc_item_t      push_item;
  wltc_item_t      head;
  logic [UB_W-1:0] unique_blocks_r;
  logic            cfg_write;

  // Register port: a single register, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[CFG_AW-1] == REG_UNIQUE_BLOCKS)
                     ? CFG_DW'(unique_blocks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unique_blocks_r <= '0;
    end else if (cfg_write && (paddr[CFG_AW-1] == REG_UNIQUE_BLOCKS)) begin
      unique_blocks_r <= pwdata[UB_W-1:0];
    end
  end

  wltc_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_block_address (in_block_address),
    .clearing         (clearing),
    .queue_full       (queue_full),
    .push             (push),
    .push_item        (push_item)
  );

  wltc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  wltc_back #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .MAX_LIFESPAN (MAX_LIFESPAN)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .unique_blocks      (unique_blocks_r),
    .queue_empty        (queue_empty),
    .head               (head),
    .pop                (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_r_index        (out_r_index),
    .out_g_index        (out_g_index),
    .out_within_count   (out_within_count),
    .out_beyond_g_count (out_beyond_g_count),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/core/wltc_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module wltc_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/wltc_front.sv
// Front part: accepts items, drops writes beyond the map and stamps sequence numbers.
`default_nettype none

module wltc_front
  import wltc_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              in_kind,
  input  wire logic [ADDR_W-1:0] in_block_address,
  input  wire logic              clearing,
  input  wire logic              queue_full,
  output      logic              push,
  output      wltc_item_t        push_item
);

  localparam int unsigned NB_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W = (NB_W > ADDR_W) ? NB_W : ADDR_W;

  logic             accept;
  logic             in_range;
  logic [SEQ_W-1:0] seq_r;
  logic [SEQ_W-1:0] seq_nxt;
  logic [SEQ_W-1:0] seq_inc;

  // No item is taken while the map is being cleared or the queue is full.
  assign in_stall = clearing | queue_full;
  assign accept   = in_valid & ~in_stall;

  // A write beyond the map is accepted and then forgotten.
  assign in_range  = CMP_W'(in_block_address) < CMP_W'(NUM_BLOCKS);
  assign push      = accept & ((in_kind == KIND_REPORT) | in_range);
  assign push_item = '{kind: in_kind, addr: in_block_address, seq: seq_r};

  // Running sequence number, wraps past zero straight to one.
  assign seq_inc = seq_r + SEQ_W'(1);
  always_comb begin
    seq_nxt = seq_r;
    if (push && (in_kind == KIND_WRITE)) begin
      seq_nxt = (seq_inc == '0) ? SEQ_W'(1) : seq_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_W'(1);
    end else begin
      seq_r <= seq_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wltc_queue.sv
// Short item queue between the front and back parts.
`default_nettype none

module wltc_queue
  import wltc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire wltc_item_t push_item,
  output      logic       full,
  input  wire logic       pop,
  output      logic       empty,
  output      wltc_item_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  wltc_item_t        store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign head    = store_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wltc_back.sv
// Back part: map read-modify-write, threshold counting and report output.
`default_nettype none

module wltc_back
  import wltc_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS   = DEF_NUM_BLOCKS,
  parameter int unsigned MAX_LIFESPAN = DEF_MAX_LIFESPAN
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [UB_W-1:0]  unique_blocks,
  input  wire logic             queue_empty,
  input  wire wltc_item_t       head,
  output      logic             pop,
  output      logic             clearing,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [IDX_W-1:0] out_r_index,
  output      logic [IDX_W-1:0] out_g_index,
  output      logic [CNT_W-1:0] out_within_count,
  output      logic [CNT_W-1:0] out_beyond_g_count,
  output      logic             out_last
);

  localparam int unsigned MAP_DEPTH = (NUM_BLOCKS < (1 << ADDR_W)) ? NUM_BLOCKS : (1 << ADDR_W);
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned LIFE_W    = $clog2(MAX_LIFESPAN);
  localparam int unsigned DIST_W    = SEQ_W - SEQ_SHIFT;
  localparam int unsigned SCL_W     = LIFE_W + SCALE_W;
  localparam int unsigned CMPV_W    = (SCL_W > THR_W) ? SCL_W : THR_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_COUNT  = 5'b01000,
    S_REPORT = 5'b10000
  } back_state_t;

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [MAP_AW-1:0] clr_addr_r;
  logic [MAP_AW-1:0] clr_addr_nxt;
  logic [MAP_AW-1:0] cur_addr_r;
  logic [SEQ_W-1:0]  cur_seq_r;
  logic [LIFE_W-1:0] life_r;
  logic [LIFE_W-1:0] life_nxt;
  logic              hit_r;
  logic [PAIR_W-1:0] pair_r;
  logic [PAIR_W-1:0] pair_nxt;

  logic              ram_we;
  logic [MAP_AW-1:0] ram_waddr;
  logic [SEQ_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [SEQ_W-1:0]  ram_rdata;

  logic [SEQ_W-1:0]  seq_diff;
  logic [DIST_W-1:0] seq_span;
  logic [CMPV_W-1:0] scaled;
  logic [NUM_PAIRS-1:0] beyond_hit;
  logic [NUM_PAIRS-1:0] within_hit;

  logic [THR_W-1:0]  bthr_r [NUM_PAIRS];
  logic [THR_W-1:0]  wthr_r [NUM_PAIRS];
  logic [CNT_W-1:0]  beyond_r [NUM_PAIRS];
  logic [CNT_W-1:0]  within_r [NUM_PAIRS];

  logic              out_valid_r;
  logic              out_load;
  logic [IDX_W-1:0]  out_r_index_r;
  logic [IDX_W-1:0]  out_g_index_r;
  logic [CNT_W-1:0]  out_within_r;
  logic [CNT_W-1:0]  out_beyond_r;
  logic              out_last_r;

  // Last-write map, one sequence number per block.
  wltc_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head.addr[MAP_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign clearing = (state_r == S_CLEAR);
  assign out_load = (state_r == S_REPORT) && (!out_valid_r || !out_stall);

  // Lifespan from the sequence distance, saturated.
  assign seq_diff = cur_seq_r - ram_rdata;
  assign seq_span = seq_diff[SEQ_W-1:SEQ_SHIFT];
  assign life_nxt = (seq_span > DIST_W'(MAX_LIFESPAN - 1)) ? LIFE_W'(MAX_LIFESPAN - 1)
                                                           : seq_span[LIFE_W-1:0];

  // Lifespan times 2560 against every threshold pair.
  always_comb begin
    scaled = (CMPV_W'(life_r) << SCALE_HI_SH) + (CMPV_W'(life_r) << SCALE_LO_SH);
    for (int k = 0; k < NUM_PAIRS; k++) begin
      beyond_hit[k] = scaled >= CMPV_W'(bthr_r[k]);
      within_hit[k] = beyond_hit[k] && (scaled <= CMPV_W'(wthr_r[k]));
    end
  end

  // Thresholds track the register; change it only when the block is idle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      bthr_r[k] <= THR_W'(unique_blocks) * THR_W'(G_TENTHS[k % NUM_G]);
      wthr_r[k] <= THR_W'(unique_blocks) *
                   THR_W'(G_TENTHS[k % NUM_G] + R_TENTHS[k / NUM_G]);
    end
  end

  // Sequencer and map port control.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    pair_nxt     = pair_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = cur_addr_r;
    ram_wdata    = cur_seq_r;
    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + MAP_AW'(1);
        if (clr_addr_r == MAP_AW'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!queue_empty) begin
          pop = 1'b1;
          if (head.kind == KIND_REPORT) begin
            pair_nxt  = '0;
            state_nxt = S_REPORT;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        ram_we    = 1'b1;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        state_nxt = S_IDLE;
      end
      S_REPORT: begin
        if (out_load) begin
          pair_nxt = pair_r + PAIR_W'(1);
          if (pair_r == PAIR_W'(NUM_PAIRS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      pair_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pair_r     <= pair_nxt;
    end
  end

  // Item being worked on and its lifespan.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr_r <= head.addr[MAP_AW-1:0];
      cur_seq_r  <= head.seq;
    end
    if (state_r == S_READ) begin
      life_r <= life_nxt;
      hit_r  <= (ram_rdata != '0);
    end
  end

  // Threshold counters, all pairs updated together for a rewrite.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        beyond_r[k] <= '0;
        within_r[k] <= '0;
      end
    end else if ((state_r == S_COUNT) && hit_r) begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
        if (beyond_hit[k]) begin
          beyond_r[k] <= beyond_r[k] + CNT_W'(1);
        end
        if (within_hit[k]) begin
          within_r[k] <= within_r[k] + CNT_W'(1);
        end
      end
    end
  end

  // Output register: one counter pair per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r_index_r <= pair_r[PAIR_W-1:PAIR_W-IDX_W];
      out_g_index_r <= pair_r[IDX_W-1:0];
      out_within_r  <= within_r[pair_r];
      out_beyond_r  <= beyond_r[pair_r];
      out_last_r    <= (pair_r == PAIR_W'(NUM_PAIRS - 1));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_r_index        = out_r_index_r;
  assign out_g_index        = out_g_index_r;
  assign out_within_count   = out_within_r;
  assign out_beyond_g_count = out_beyond_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/wltc_checker.sv
// Port-level checks on the write lifespan threshold counter, bound to the top level.
`default_nettype none

module wltc_checker
  import wltc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [IDX_W-1:0]  out_r_index,
  input wire logic [IDX_W-1:0]  out_g_index,
  input wire logic [CNT_W-1:0]  out_within_count,
  input wire logic [CNT_W-1:0]  out_beyond_g_count,
  input wire logic              out_last
);

  // A stalled result item keeps its place and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_within_count)
      && $stable(out_beyond_g_count) && $stable(out_last))
    else $error("stalled result item changed");

  // The last item of a report is always the final pair.
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_r_index == 2'd2) && (out_g_index == 2'd3))
    else $error("last flag on a pair other than the final one");

  // Only three window multiples exist.
  a_r_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r_index != 2'd3))
    else $error("window index out of range");

  // A lifespan inside the window is also beyond its start.
  a_within_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_within_count <= out_beyond_g_count))
    else $error("within count exceeds beyond count");

  // Within a window row, a result straight after an accepted one has the next start index.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last && (out_g_index != 2'd3) ##1 out_valid
      |-> (out_g_index == $past(out_g_index) + 2'd1)
          && (out_r_index == $past(out_r_index)))
    else $error("report pairs out of order");

endmodule

bind write_lifespan_threshold_counter wltc_checker u_wltc_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the write lifespan threshold counter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wltc_pkg::*;

  // Testbench constants
  localparam int unsigned BLOCK_COUNT    = DEF_NUM_BLOCKS;
  localparam longint unsigned LIFE_CAP   = DEF_MAX_LIFESPAN - 1;
  localparam longint unsigned LIFE_SCALE = 2560;
  localparam int unsigned GRANULE_SHIFT  = 8;
  localparam int unsigned R_COUNT        = 3;
  localparam int unsigned G_COUNT        = 4;
  localparam int unsigned PAIR_COUNT     = R_COUNT * G_COUNT;
  localparam int unsigned UNUSED_REG     = 1;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned HOT_POOL_SIZE  = 8;
  localparam int unsigned REPORT_PCT     = 7;
  localparam int unsigned MAX_SHOWN      = 10;
  // The map clearing pass after reset keeps the input stalled while all 2^20 entries are cleared.
  localparam int unsigned QUIET_LIMIT    = 3 * (1 << 20);

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
  } block_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] g_idx;
    logic [CNT_W-1:0] window_cnt;
    logic [CNT_W-1:0] beyond;
    logic             last;
  } pair_report_t;

  // Clock, reset and block ports
  logic              clk;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic              in_kind          = KIND_WRITE;
  logic [ADDR_W-1:0] in_block_address = '0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [IDX_W-1:0]  out_r_index;
  logic [IDX_W-1:0]  out_g_index;
  logic [CNT_W-1:0]  out_within_count;
  logic [CNT_W-1:0]  out_beyond_g_count;
  logic              out_last;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [CFG_AW-1:0] paddr            = '0;
  logic [CFG_DW-1:0] pwdata           = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Stimulus and expectation stores
  block_item_t       pending_items[$];
  pair_report_t      expected_pairs[$];
  logic [ADDR_W-1:0] touched_addrs[$];
  logic [ADDR_W-1:0] hot_addrs[$];

  // Shadow state of the block
  logic [SEQ_W-1:0]  seq_map [int unsigned];
  logic [SEQ_W-1:0]  seq_now = SEQ_W'(1);
  logic [CNT_W-1:0]  within_tally [PAIR_COUNT];
  logic [CNT_W-1:0]  beyond_tally [PAIR_COUNT];
  logic [UB_W-1:0]   blocks_cfg = '0;

  // Bookkeeping shared by the processes
  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 0;
  int unsigned hold_asked   = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned in_gap_left  = 0;
  logic        in_took      = 1'b0;

  write_lifespan_threshold_counter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_r_index        (out_r_index),
    .out_g_index        (out_g_index),
    .out_within_count   (out_within_count),
    .out_beyond_g_count (out_beyond_g_count),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < PAIR_COUNT; k++) begin
      within_tally[k] = '0;
      beyond_tally[k] = '0;
    end
  end

  // Multiples in tenths for the window and start of each threshold pair.
  function automatic longint unsigned window_tenths(int unsigned i);
    case (i)
      0:       return 4;
      1:       return 8;
      default: return 16;
    endcase
  endfunction

  function automatic longint unsigned start_tenths(int unsigned j);
    case (j)
      0:       return 8;
      1:       return 16;
      2:       return 32;
      default: return 64;
    endcase
  endfunction

  function automatic void note_fault(string what);
    fault_count++;
    if (fault_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Fold one accepted item into the shadow state, queueing any report results.
  function automatic void predict_item(logic kind, logic [ADDR_W-1:0] addr);
    logic [SEQ_W-1:0] prev;
    logic [SEQ_W-1:0] gap;
    longint unsigned  life;
    longint unsigned  scaled;
    longint unsigned  start_thr;
    longint unsigned  end_thr;
    pair_report_t     pr;
    int unsigned      i;
    int unsigned      j;
    int unsigned      k;
    if (kind == KIND_WRITE) begin
      if (addr < BLOCK_COUNT) begin
        prev = seq_map.exists(addr) ? seq_map[addr] : '0;
        // Zero marks a block that has never been written: no lifespan then.
        if (prev != '0) begin
          gap  = seq_now - prev;
          life = 64'(gap >> GRANULE_SHIFT);
          if (life > LIFE_CAP) life = LIFE_CAP;
          scaled = life * LIFE_SCALE;
          for (i = 0; i < R_COUNT; i++) begin
            for (j = 0; j < G_COUNT; j++) begin
              k         = i * G_COUNT + j;
              start_thr = 64'(blocks_cfg) * start_tenths(j);
              end_thr   = 64'(blocks_cfg) * (start_tenths(j) + window_tenths(i));
              if (scaled >= start_thr) begin
                beyond_tally[k] = beyond_tally[k] + 1'b1;
                if (scaled <= end_thr) within_tally[k] = within_tally[k] + 1'b1;
              end
            end
          end
        end
        seq_map[addr] = seq_now;
        // The sequence number skips zero when it wraps.
        seq_now = seq_now + 1'b1;
        if (seq_now == '0) seq_now = SEQ_W'(1);
      end
    end else begin
      for (k = 0; k < PAIR_COUNT; k++) begin
        pr.r_idx      = IDX_W'(k / G_COUNT);
        pr.g_idx      = IDX_W'(k % G_COUNT);
        pr.window_cnt = within_tally[k];
        pr.beyond     = beyond_tally[k];
        pr.last       = (k == PAIR_COUNT - 1);
        expected_pairs.insert(expected_pairs.size(), pr);
      end
    end
  endfunction

  // Compare one accepted result with the oldest expectation, field by field.
  function automatic void check_result();
    pair_report_t want;
    if (expected_pairs.size() == 0) begin
      note_fault($sformatf("unexpected result r=%0d g=%0d within=%0h beyond=%0h last=%0b",
                           out_r_index, out_g_index, out_within_count,
                           out_beyond_g_count, out_last));
    end else begin
      want = expected_pairs.pop_front();
      if (out_r_index != want.r_idx)
        note_fault($sformatf("r_index expected %0d got %0d", want.r_idx, out_r_index));
      if (out_g_index != want.g_idx)
        note_fault($sformatf("g_index expected %0d got %0d", want.g_idx, out_g_index));
      if (out_within_count != want.window_cnt)
        note_fault($sformatf("within_count (r=%0d g=%0d) expected %0h got %0h",
                             want.r_idx, want.g_idx, want.window_cnt, out_within_count));
      if (out_beyond_g_count != want.beyond)
        note_fault($sformatf("beyond_g_count (r=%0d g=%0d) expected %0h got %0h",
                             want.r_idx, want.g_idx, want.beyond, out_beyond_g_count));
      if (out_last != want.last)
        note_fault($sformatf("last expected %0b got %0b", want.last, out_last));
    end
  endfunction

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_item(in_kind, in_block_address);
    end
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Input driver: offers pending items, with random gaps between them.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_took) void'(pending_items.pop_front());
      if (in_valid && !in_took) begin
        // A stalled item stays on the port unchanged.
      end else if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_gap_left = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid         <= 1'b1;
        in_kind          <= pending_items[0].kind;
        in_block_address <= pending_items[0].addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("[%0t] no item accepted for %0d cycles", $realtime, QUIET_LIMIT);
    $display("FAIL write_lifespan_threshold_counter");
    $finish;
  end

  // One register write then a read-back of unique_blocks.
  task automatic cfg_access(int unsigned reg_index, logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(reg_index * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_index == REG_UNIQUE_BLOCKS) blocks_cfg = value[UB_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_AW'(REG_UNIQUE_BLOCKS * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != CFG_DW'(blocks_cfg))
      note_fault($sformatf("unique_blocks read back %0h expected %0h", prdata, blocks_cfg));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void queue_item(logic kind, logic [ADDR_W-1:0] addr);
    block_item_t it;
    it.kind = kind;
    it.addr = addr;
    pending_items.insert(pending_items.size(), it);
    if (kind == KIND_WRITE) touched_addrs.insert(touched_addrs.size(), addr);
  endfunction

  // Mostly rewrites: recent hot blocks give short lifespans, old blocks long ones.
  function automatic void queue_random_item();
    int unsigned       roll;
    logic [ADDR_W-1:0] addr;
    roll = $urandom_range(99);
    if (roll < REPORT_PCT) begin
      queue_item(KIND_REPORT, ADDR_W'($urandom));
    end else if (roll < 40 && touched_addrs.size() != 0) begin
      queue_item(KIND_WRITE, touched_addrs[$urandom_range(0, touched_addrs.size() - 1)]);
    end else if (roll < 70 && hot_addrs.size() != 0) begin
      queue_item(KIND_WRITE, hot_addrs[$urandom_range(0, hot_addrs.size() - 1)]);
    end else begin
      addr = ADDR_W'($urandom);
      hot_addrs.insert(hot_addrs.size(), addr);
      if (hot_addrs.size() > HOT_POOL_SIZE) void'(hot_addrs.pop_front());
      queue_item(KIND_WRITE, addr);
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_pairs.size() != 0) @(negedge clk);
  endtask

  // One phase: drain, settle, set the threshold scale, then a batch of random items and a closing report.
  task automatic run_phase(logic [UB_W-1:0] scale, int unsigned item_total,
                           int unsigned idle_level, bit squeeze);
    int unsigned n;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_access(REG_UNIQUE_BLOCKS, CFG_DW'(scale));
    idle_pct = idle_level;
    // Reports up front let results pile up behind the held-off receiver.
    if (squeeze) begin
      queue_item(KIND_REPORT, '0);
      queue_item(KIND_REPORT, '1);
      hold_asked++;
    end
    for (n = 0; n < item_total; n++) queue_random_item();
    queue_item(KIND_REPORT, '0);
  endtask

  // Main sequence
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero and full-scale thresholds, an unused register, address
    // extremes, immediate rewrites and a report carrying an address.
    cfg_access(UNUSED_REG, '1);
    cfg_access(REG_UNIQUE_BLOCKS, CFG_DW'(21'd1048576));
    cfg_access(REG_UNIQUE_BLOCKS, '0);
    queue_item(KIND_REPORT, '1);
    queue_item(KIND_WRITE, '0);
    queue_item(KIND_WRITE, '1);
    queue_item(KIND_WRITE, '0);
    queue_item(KIND_WRITE, '1);
    queue_item(KIND_WRITE, 20'h55555);
    queue_item(KIND_WRITE, 20'hAAAAA);
    queue_item(KIND_WRITE, 20'h55555);
    queue_item(KIND_WRITE, 20'hAAAAA);
    queue_item(KIND_REPORT, '0);
    queue_item(KIND_WRITE, '0);
    queue_item(KIND_REPORT, 20'h0F0F0);

    // Random phases; the scales that put a threshold exactly on a lifespan of
    // one come late, once enough writes have passed for such lifespans.
    run_phase(UB_W'(21'd1048576), 40, 30, 1'b0);
    run_phase(UB_W'($urandom_range(1, 400)), 60, 40, 1'b1);
    run_phase(UB_W'(20), 50, 25, 1'b0);
    run_phase(UB_W'(160), 60, 50, 1'b0);
    run_phase(UB_W'(80), 60, 20, 1'b0);
    run_phase(UB_W'(1), 40, 35, 1'b0);
    run_phase(UB_W'(40), 60, 0, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_pairs.size() != 0)
      $display("%0d expected results never arrived", expected_pairs.size());
    if (fault_count == 0 && expected_pairs.size() == 0) begin
      $display("PASS write_lifespan_threshold_counter");
    end else begin
      $display("FAIL write_lifespan_threshold_counter");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/wltc_pkg.sv
rtl/core/wltc_ram.sv
rtl/core/wltc_front.sv
rtl/core/wltc_queue.sv
rtl/core/wltc_back.sv
rtl/core/write_lifespan_threshold_counter.sv
rtl/core/wltc_checker.sv
verif/testbench.sv
